/* hdl/gcsr_pkg.sv */
// ----------------------------------------------------------------------------
// gcsr_pkg: shared types and constants of the stripe replacement core
// Holds the transaction payload types, the mode codes and the parameter
// defaults used by the core and its slot store.
// ----------------------------------------------------------------------------
package gcsr_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int COUNT_BITS_DEF = 4;
    localparam int KEY_BITS_DEF   = 32;

    localparam int KEY_W     = 32;
    localparam int IDX_OUT_W = 6;

    localparam logic MODE_ACCESS = 1'b0;
    localparam logic MODE_NOTIFY = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] stripe_key;
    } t_in_item;

    typedef struct packed {
        logic                 was_hit;
        logic [IDX_OUT_W-1:0] slot_index;
        logic                 did_evict;
        logic [KEY_W-1:0]     victim_key;
    } t_out_item;

endpackage

/* hdl/gclock_stripe_replacement_core.sv */
// ----------------------------------------------------------------------------
// gclock_stripe_replacement_core: generalized CLOCK stripe slot replacement
// Looks up a stripe key among the filled slots, bumps its usage counter on a
// hit, and on an access miss fills a free slot or sweeps the clock hand to
// pick and report a victim.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge with start high and busy low.
// Busy stays high until the result has been issued; each transaction gives
// exactly one result, shown on o_result for one cycle with o_done high.
// The receiver cannot stall, so o_done is never held back.
// The lookup scans the filled slots one per cycle through the registered
// read port of the slot store into a single tag compare in the core.
// When all slots are full, an access miss sweeps the clock hand to find a
// victim, taking up to SLOTS * (2^COUNT_BITS - 1) + 1 hand steps.
// The next transaction can be accepted in the cycle o_done is high.
// Reset empties all slots and parks the hand at slot zero;
// no clearing pass runs, since the fill count marks which slots hold data.
// ----------------------------------------------------------------------------
module gclock_stripe_replacement_core #(
    parameter int SLOTS      = gcsr_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = gcsr_pkg::COUNT_BITS_DEF,
    parameter int KEY_BITS   = gcsr_pkg::KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  gcsr_pkg::t_in_item  i_item,
    output logic                o_done,
    output gcsr_pkg::t_out_item o_result
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int FILL_W = IDX_W + 1;
    localparam int TAG_W = (KEY_BITS < gcsr_pkg::KEY_W) ? KEY_BITS : gcsr_pkg::KEY_W;
    localparam logic [FILL_W-1:0] SlotsFull = FILL_W'(SLOTS);
    localparam logic [IDX_W-1:0] LastSlot = IDX_W'(SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_MISS,
        ST_SWEEP
    } t_state;

    t_state                r_state, n_state;
    logic                  r_mode;
    logic [TAG_W-1:0]      r_key;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_hand, n_hand;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic                  r_done, n_done;
    gcsr_pkg::t_out_item   r_res, n_res;

    logic [IDX_W-1:0]      rd_addr;
    logic [TAG_W-1:0]      rd_tag;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [TAG_W-1:0]      wr_tag;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic [IDX_W-1:0]      idx_next;
    logic [IDX_W-1:0]      hand_next;
    logic                  accept;

    gcsr_slot_store #(
        .SLOTS      (SLOTS),
        .TAG_W      (TAG_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_tag  (rd_tag),
        .o_rd_cnt  (rd_cnt),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_tag  (wr_tag),
        .i_wr_cnt  (wr_cnt)
    );

    assign accept    = start && !busy;
    assign idx_next  = r_idx + IDX_W'(1);
    assign hand_next = (r_hand == LastSlot) ? '0 : r_hand + IDX_W'(1);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_hand  = r_hand;
        n_fill  = r_fill;
        n_done  = 1'b0;
        n_res   = '0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_tag  = rd_tag;
        wr_cnt  = rd_cnt;
        unique case (r_state)
            ST_IDLE: begin
                rd_addr = '0;
                if (accept) begin
                    n_idx   = '0;
                    n_state = (r_fill == '0) ? ST_MISS : ST_LOOK;
                end
            end
            ST_LOOK: begin
                rd_addr = idx_next;
                if (rd_tag == r_key) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_idx;
                    wr_tag   = rd_tag;
                    wr_cnt   = (rd_cnt == CountMax) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
                    n_done   = 1'b1;
                    n_res.was_hit    = 1'b1;
                    n_res.slot_index = gcsr_pkg::IDX_OUT_W'(r_idx);
                    n_state  = ST_IDLE;
                end else if (FILL_W'(r_idx) + FILL_W'(1) < r_fill) begin
                    n_idx = idx_next;
                end else begin
                    n_state = ST_MISS;
                end
            end
            ST_MISS: begin
                rd_addr = r_hand;
                if (r_mode == gcsr_pkg::MODE_NOTIFY) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_fill < SlotsFull) begin
                    wr_en    = 1'b1;
                    wr_addr  = IDX_W'(r_fill);
                    wr_tag   = r_key;
                    wr_cnt   = '0;
                    n_fill   = r_fill + FILL_W'(1);
                    n_done   = 1'b1;
                    n_res.slot_index = gcsr_pkg::IDX_OUT_W'(r_fill);
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                rd_addr = hand_next;
                n_hand  = hand_next;
                wr_en   = 1'b1;
                wr_addr = r_hand;
                if (rd_cnt != '0) begin
                    wr_tag = rd_tag;
                    wr_cnt = rd_cnt - COUNT_BITS'(1);
                end else begin
                    wr_tag   = r_key;
                    wr_cnt   = '0;
                    n_done   = 1'b1;
                    n_res.slot_index = gcsr_pkg::IDX_OUT_W'(r_hand);
                    n_res.did_evict  = 1'b1;
                    n_res.victim_key = gcsr_pkg::KEY_W'(rd_tag);
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_hand  <= '0;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_hand  <= n_hand;
            r_fill  <= n_fill;
            r_done  <= n_done;
        end
        r_res <= n_res;
        if (accept) begin
            r_mode <= i_item.mode;
            r_key  <= i_item.stripe_key[TAG_W-1:0];
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    a_done_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == ST_IDLE))
        else $error("Result strobe raised while the sequencer is still working.");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("Accepted transaction did not make the block busy.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SlotsFull)
        else $error("Fill count exceeds the number of slots.");

    a_evict_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res.did_evict) |-> (r_fill == SlotsFull && !r_res.was_hit))
        else $error("Eviction reported while free slots remain or on a hit.");

    a_sweep_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_fill == SlotsFull && r_mode == gcsr_pkg::MODE_ACCESS))
        else $error("Hand sweep started without a full slot set on an access.");

endmodule

/* hdl/gcsr_slot_store.sv */
// ----------------------------------------------------------------------------
// gcsr_slot_store: tag and usage counter storage
// One registered read port and one write port over the per-slot tag and
// usage counter arrays. Contents are undefined until written.
// ----------------------------------------------------------------------------
module gcsr_slot_store #(
    parameter int SLOTS      = gcsr_pkg::SLOTS_DEF,
    parameter int TAG_W      = gcsr_pkg::KEY_W,
    parameter int COUNT_BITS = gcsr_pkg::COUNT_BITS_DEF,
    localparam int IDX_W     = $clog2(SLOTS)
) (
    input  logic                  i_clk,
    input  logic [IDX_W-1:0]      i_rd_addr,
    output logic [TAG_W-1:0]      o_rd_tag,
    output logic [COUNT_BITS-1:0] o_rd_cnt,
    input  logic                  i_wr_en,
    input  logic [IDX_W-1:0]      i_wr_addr,
    input  logic [TAG_W-1:0]      i_wr_tag,
    input  logic [COUNT_BITS-1:0] i_wr_cnt
);

    logic [TAG_W-1:0]      r_tag_mem [SLOTS];
    logic [COUNT_BITS-1:0] r_cnt_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_wr_addr] <= i_wr_tag;
            r_cnt_mem[i_wr_addr] <= i_wr_cnt;
        end
        o_rd_tag <= r_tag_mem[i_rd_addr];
        o_rd_cnt <= r_cnt_mem[i_rd_addr];
    end

endmodule
